[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int SUM_W  = 65;
   localparam int QUO_W  = 33;
   localparam int ROOT_W = 32;
   localparam int STEP_CNT = 33;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;
   localparam int REQ_W  = 136;
   localparam int RSP_W  = 72;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MAG = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK  = 2'd0,
      ST_DZ  = 2'd1,
      ST_OVF = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              ovf;
   } sat_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] fast_re;
      logic [DATA_W-1:0] fast_im;
      logic              fast_ovf;
      logic              neg_re;
      logic              neg_im;
      logic              big_re;
      logic              big_im;
      logic              dz;
   } side_type;

   localparam logic signed [SUM_W-1:0] SAT_MAX = 65'sh0_7fff_ffff;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -65'sh0_8000_0000;

   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.val = 32'h7fff_ffff;
         r.ovf = 1'b1;
      end else if (v < SAT_MIN) begin
         r.val = 32'h8000_0000;
         r.ovf = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Three stages: partial products, product sums, then add/sub/multiply results
// and divider operand preparation.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [cau_pkg::OP_W-1:0]              op,
   input  logic signed [cau_pkg::DATA_W-1:0]     a_re,
   input  logic signed [cau_pkg::DATA_W-1:0]     a_im,
   input  logic signed [cau_pkg::DATA_W-1:0]     b_re,
   input  logic signed [cau_pkg::DATA_W-1:0]     b_im,
   output logic                                  out_valid,
   output cau_pkg::side_type                     side,
   output logic [cau_pkg::PROD_W+FRAC_BITS-1:0]  num_re,
   output logic [cau_pkg::PROD_W+FRAC_BITS-1:0]  num_im,
   output logic [cau_pkg::PROD_W-1:0]            den
);
   import cau_pkg::*;

   localparam int NUM_W = PROD_W + FRAC_BITS;

   // stage 1
   logic                     v1_ff;
   logic [OP_W-1:0]          op1_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   sat_type                  as_re1_ff, as_im1_ff, as_re_in, as_im_in;
   logic signed [DATA_W-1:0] m0, m1;

   // stage 2
   logic                     v2_ff;
   logic [OP_W-1:0]          op2_ff;
   sat_type                  as_re2_ff, as_im2_ff;
   logic signed [SUM_W-1:0]  s_re_ff, s_im_ff, s_re_in, s_im_in;
   logic [PROD_W-1:0]        den2_ff, den2_in;

   // stage 3
   logic                     v3_ff;
   side_type                 side_ff, side_in;
   logic [NUM_W-1:0]         num_re_ff, num_im_ff, num_re_in, num_im_in;
   logic [PROD_W-1:0]        den3_ff;
   logic signed [SUM_W-1:0]  sh_re, sh_im, ab_re, ab_im;
   sat_type                  mul_re, mul_im;

   always_comb begin
      m0 = (op == OP_MAG) ? a_re : b_re;
      m1 = (op == OP_MAG) ? a_im : b_im;
      p0_in = a_re * b_re;
      p1_in = a_im * b_im;
      p2_in = a_re * b_im;
      p3_in = a_im * b_re;
      p4_in = m0 * m0;
      p5_in = m1 * m1;
      if (op == OP_SUB) begin
         as_re_in = sat32(SUM_W'(a_re) - SUM_W'(b_re));
         as_im_in = sat32(SUM_W'(a_im) - SUM_W'(b_im));
      end else begin
         as_re_in = sat32(SUM_W'(a_re) + SUM_W'(b_re));
         as_im_in = sat32(SUM_W'(a_im) + SUM_W'(b_im));
      end
   end

   always_comb begin
      if (op1_ff == OP_MUL) begin
         s_re_in = SUM_W'(p0_ff) - SUM_W'(p1_ff);
         s_im_in = SUM_W'(p2_ff) + SUM_W'(p3_ff);
      end else begin
         s_re_in = SUM_W'(p0_ff) + SUM_W'(p1_ff);
         s_im_in = SUM_W'(p3_ff) - SUM_W'(p2_ff);
      end
      den2_in = p4_ff + p5_ff;
   end

   always_comb begin
      sh_re  = s_re_ff >>> FRAC_BITS;
      sh_im  = s_im_ff >>> FRAC_BITS;
      mul_re = sat32(sh_re);
      mul_im = sat32(sh_im);
      ab_re  = s_re_ff[SUM_W-1] ? -s_re_ff : s_re_ff;
      ab_im  = s_im_ff[SUM_W-1] ? -s_im_ff : s_im_ff;
      num_re_in = NUM_W'(ab_re[PROD_W-1:0]) << FRAC_BITS;
      num_im_in = NUM_W'(ab_im[PROD_W-1:0]) << FRAC_BITS;
      side_in.op     = op2_ff;
      side_in.neg_re = s_re_ff[SUM_W-1];
      side_in.neg_im = s_im_ff[SUM_W-1];
      side_in.big_re = (num_re_in >> QUO_W) >= NUM_W'(den2_ff);
      side_in.big_im = (num_im_in >> QUO_W) >= NUM_W'(den2_ff);
      side_in.dz     = (den2_ff == '0);
      if (op2_ff == OP_MUL) begin
         side_in.fast_re  = mul_re.val;
         side_in.fast_im  = mul_im.val;
         side_in.fast_ovf = mul_re.ovf | mul_im.ovf;
      end else begin
         side_in.fast_re  = as_re2_ff.val;
         side_in.fast_im  = as_im2_ff.val;
         side_in.fast_ovf = as_re2_ff.ovf | as_im2_ff.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff    <= op;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
         p5_ff     <= p5_in;
         as_re1_ff <= as_re_in;
         as_im1_ff <= as_im_in;
         op2_ff    <= op1_ff;
         as_re2_ff <= as_re1_ff;
         as_im2_ff <= as_im1_ff;
         s_re_ff   <= s_re_in;
         s_im_ff   <= s_im_in;
         den2_ff   <= den2_in;
         side_ff   <= side_in;
         num_re_ff <= num_re_in;
         num_im_ff <= num_im_in;
         den3_ff   <= den2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign side      = side_ff;
   assign num_re    = num_re_ff;
   assign num_im    = num_im_ff;
   assign den       = den3_ff;

endmodule

[rtl/cau_divider.sv]
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_divider #(
   parameter int NUM_W = 80
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [NUM_W-1:0]            num,
   input  logic [cau_pkg::PROD_W-1:0]  den,
   output logic [cau_pkg::QUO_W-1:0]   quo
);
   import cau_pkg::*;

   logic [PROD_W-1:0] rem_ff [0:QUO_W-1];
   logic [QUO_W-1:0]  q_ff   [0:QUO_W-1];
   logic [NUM_W-1:0]  n_ff   [0:QUO_W-1];
   logic [PROD_W-1:0] d_ff   [0:QUO_W-1];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [PROD_W-1:0] rem_prev, d_prev, rem_in;
      logic [QUO_W-1:0]  q_prev, q_in;
      logic [NUM_W-1:0]  n_prev;
      logic [PROD_W:0]   trial, diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev = PROD_W'(num >> QUO_W);
         assign q_prev   = '0;
         assign n_prev   = num;
         assign d_prev   = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign n_prev   = n_ff[k-1];
         assign d_prev   = d_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, n_prev[QUO_W-1-k]};
         diff   = trial - {1'b0, d_prev};
         ge     = (trial >= {1'b0, d_prev});
         rem_in = ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
         q_in   = q_prev;
         q_in[QUO_W-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            n_ff[k]   <= n_prev;
            d_ff[k]   <= d_prev;
         end
      end
   end

   assign quo = q_ff[QUO_W-1];

endmodule

[rtl/cau_isqrt.sv]
// ----------------------------------------------------------------------------
// cau_isqrt
// Pipelined integer square root, one root bit per stage, saturating output.
// ----------------------------------------------------------------------------
module cau_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [cau_pkg::PROD_W-1:0]  rad,
   output logic [cau_pkg::DATA_W-1:0]  root,
   output logic                        ovf
);
   import cau_pkg::*;

   logic [PROD_W-1:0] r_ff [0:ROOT_W-1];
   logic [ROOT_W-1:0] q_ff [0:ROOT_W-1];
   logic [DATA_W-1:0] root_ff;
   logic              ovf_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int BIT = ROOT_W - 1 - k;
      logic [PROD_W-1:0] r_prev, r_in;
      logic [ROOT_W-1:0] q_prev, q_in;
      logic [PROD_W:0]   t, diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign r_prev = rad;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign q_prev = q_ff[k-1];
      end

      always_comb begin
         t    = ((PROD_W+1)'(q_prev) << (BIT + 1)) | ((PROD_W+1)'(1) << (2 * BIT));
         diff = {1'b0, r_prev} - t;
         ge   = ({1'b0, r_prev} >= t);
         r_in = ge ? diff[PROD_W-1:0] : r_prev;
         q_in = q_prev;
         q_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
            q_ff[k] <= q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff  <= q_ff[ROOT_W-1][ROOT_W-1];
         root_ff <= q_ff[ROOT_W-1][ROOT_W-1] ? 32'h7fff_ffff : q_ff[ROOT_W-1];
      end
   end

   assign root = root_ff;
   assign ovf  = ovf_ff;

endmodule

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and magnitude on Q16.16 operands.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 33 divider/square-root stages and 1 output
// register between req transfer and rsp_tvalid.
// Throughput: one transfer per cycle; the whole pipeline holds while a
// result waits on rsp_tready.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // op[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99], zero pad
   input  logic [cau_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // res_re[31:0], res_im[63:32], status[65:64], zero pad
   output logic [cau_pkg::RSP_W-1:0]    rsp_tdata
);
   import cau_pkg::*;

   localparam int NUM_W = PROD_W + FRAC_BITS;

   logic              en;
   logic              f_valid;
   side_type          f_side;
   logic [NUM_W-1:0]  f_num_re, f_num_im;
   logic [PROD_W-1:0] f_den;
   logic [QUO_W-1:0]  q_re, q_im;
   logic [DATA_W-1:0] root;
   logic              root_ovf;

   logic              vld_ff  [0:STEP_CNT-1];
   side_type          side_ff [0:STEP_CNT-1];

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic [STAT_W-1:0] status_ff, status_in;

   side_type          sd;
   logic              ovf_re, ovf_im;
   logic [DATA_W-1:0] dv_re, dv_im;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .op        (req_tdata[2:0]),
      .a_re      (req_tdata[34:3]),
      .a_im      (req_tdata[66:35]),
      .b_re      (req_tdata[98:67]),
      .b_im      (req_tdata[130:99]),
      .out_valid (f_valid),
      .side      (f_side),
      .num_re    (f_num_re),
      .num_im    (f_num_im),
      .den       (f_den)
   );

   cau_divider #(.NUM_W(NUM_W)) u_div_re (
      .clock (clock),
      .en    (en),
      .num   (f_num_re),
      .den   (f_den),
      .quo   (q_re)
   );

   cau_divider #(.NUM_W(NUM_W)) u_div_im (
      .clock (clock),
      .en    (en),
      .num   (f_num_im),
      .den   (f_den),
      .quo   (q_im)
   );

   cau_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (f_den),
      .root  (root),
      .ovf   (root_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEP_CNT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= f_valid;
         for (int i = 1; i < STEP_CNT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[STEP_CNT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= f_side;
         for (int i = 1; i < STEP_CNT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
      end
   end

   // quotient sign, saturation, result and status select by op
   always_comb begin
      sd = side_ff[STEP_CNT-1];
      ovf_re = sd.big_re || (sd.neg_re ? (q_re > 33'h0_8000_0000)
                                       : (q_re > 33'h0_7fff_ffff));
      ovf_im = sd.big_im || (sd.neg_im ? (q_im > 33'h0_8000_0000)
                                       : (q_im > 33'h0_7fff_ffff));
      if (ovf_re) begin
         dv_re = sd.neg_re ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         dv_re = sd.neg_re ? DATA_W'(-q_re) : q_re[DATA_W-1:0];
      end
      if (ovf_im) begin
         dv_im = sd.neg_im ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         dv_im = sd.neg_im ? DATA_W'(-q_im) : q_im[DATA_W-1:0];
      end

      res_re_in = '0;
      res_im_in = '0;
      status_in = ST_OK;
      unique case (sd.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            res_re_in = sd.fast_re;
            res_im_in = sd.fast_im;
            status_in = sd.fast_ovf ? ST_OVF : ST_OK;
         end
         OP_DIV: begin
            if (sd.dz) begin
               status_in = ST_DZ;
            end else begin
               res_re_in = dv_re;
               res_im_in = dv_im;
               status_in = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
            end
         end
         OP_MAG: begin
            res_re_in = root;
            status_in = root_ovf ? ST_OVF : ST_OK;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, res_im_ff, res_re_ff};

`ifndef ASSERT_OFF
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[65:64] != 2'd3))
      else $error("undefined status code");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65:64] == ST_DZ) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("divide by zero with nonzero parts");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline stalled");

   a_mag_im_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STEP_CNT-1] && en && side_ff[STEP_CNT-1].op == OP_MAG)
         |=> (rsp_tdata[63:32] == 32'd0))
      else $error("magnitude with nonzero imaginary part");
`endif

endmodule

[test/complex_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Streams directed and random complex operations through the unit with bursty
// input and a stalling output, predicts every result in place and checks each
// output transfer field by field, in order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int FRAC       = 16;
   localparam int N_RANDOM   = 1730;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 60;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
   } cplx_req_type;

   typedef struct {
      logic [31:0] re, im;
      logic [1:0]  status;
   } cplx_rsp_type;

   logic              clock, reset;
   logic              req_tvalid, req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;

   cplx_req_type pending_ops[$];
   cplx_rsp_type expected_rsp[$];
   int      n_total, n_sent, n_checked, n_errors, cycles;
   int      op_seen[8];
   int      burst_left, gap_left, hold_left, stall_pct;
   logic    req_fire, long_hold_done;

   complex_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] clamp32(input logic signed [127:0] v, ref logic ovf);
      if (v > 128'sh7fff_ffff) begin
         ovf = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < -128'sh8000_0000) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // exact numerator * 2^FRAC / den, truncated toward zero
   function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                       input logic [63:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      mag = mag << FRAC;
      q = mag / {64'b0, den};
      return (num < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic cplx_rsp_type cplx_result(input cplx_req_type it);
      cplx_rsp_type r;
      longint ar, ai, br, bi, p1, p2;
      logic signed [127:0] w1, w2;
      logic [63:0] den, sq, t;
      logic [31:0] root;
      logic ovf;
      ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
      r.re = '0; r.im = '0; r.status = ST_OK; ovf = 1'b0;
      case (op_type'(it.op))
         OP_ADD: begin
            w1 = ar; w1 = w1 + br;
            w2 = ai; w2 = w2 + bi;
            r.re = clamp32(w1, ovf);
            r.im = clamp32(w2, ovf);
         end
         OP_SUB: begin
            w1 = ar; w1 = w1 - br;
            w2 = ai; w2 = w2 - bi;
            r.re = clamp32(w1, ovf);
            r.im = clamp32(w2, ovf);
         end
         OP_MUL: begin
            p1 = ar * br; p2 = ai * bi;
            w1 = p1; w1 = w1 - p2; w1 = w1 >>> FRAC;
            p1 = ar * bi; p2 = ai * br;
            w2 = p1; w2 = w2 + p2; w2 = w2 >>> FRAC;
            r.re = clamp32(w1, ovf);
            r.im = clamp32(w2, ovf);
         end
         OP_DIV: begin
            p1 = br * br; p2 = bi * bi;
            den = 64'(p1) + 64'(p2);
            if (den == 0) begin
               r.status = ST_DZ;
            end else begin
               p1 = ar * br; p2 = ai * bi;
               w1 = p1; w1 = w1 + p2;
               p1 = br * ai; p2 = ar * bi;
               w2 = p1; w2 = w2 - p2;
               r.re = clamp32(scaled_quot(w1, den), ovf);
               r.im = clamp32(scaled_quot(w2, den), ovf);
            end
         end
         OP_MAG: begin
            p1 = ar * ar; p2 = ai * ai;
            sq = 64'(p1) + 64'(p2);
            root = '0;
            for (int i = 31; i >= 0; i--) begin
               t = {32'b0, root | (32'h1 << i)};
               if (t * t <= sq) root = t[31:0];
            end
            if (root > 32'h7fff_ffff) begin
               root = 32'h7fff_ffff;
               ovf = 1'b1;
            end
            r.re = root;
         end
         default: ;
      endcase
      if (ovf) r.status = ST_OVF;
      return r;
   endfunction

   function automatic logic [31:0] rand_part();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom;
         5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
         default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      endcase
   endfunction

   task automatic add_item(input logic [2:0] op, input logic [31:0] ar, ai, br, bi);
      cplx_req_type it;
      it.op = op; it.a_re = ar; it.a_im = ai; it.b_re = br; it.b_im = bi;
      pending_ops.push_back(it);
      n_total++;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, want);
      n_errors++;
      $display("ERROR transfer %0d: %s got %h expected %h", n_checked, what, got, want);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            cplx_req_type it;
            it = pending_ops.pop_front();
            req_tdata <= {5'b0, it.b_im, it.b_re, it.a_im, it.a_re, it.op};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && n_sent > 500) begin
         long_hold_done = 1'b1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 3) * 25;
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // input transfers feed the predictor
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         cplx_req_type it;
         it.op = req_tdata[2:0];
         it.a_re = req_tdata[34:3];
         it.a_im = req_tdata[66:35];
         it.b_re = req_tdata[98:67];
         it.b_im = req_tdata[130:99];
         expected_rsp.push_back(cplx_result(it));
         op_seen[it.op]++;
         n_sent++;
      end
   end

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            n_errors++;
            $display("ERROR unexpected output transfer %h", rsp_tdata);
         end else begin
            cplx_rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_tdata[31:0] !== e.re) report_mismatch("res_re", rsp_tdata[31:0], e.re);
            if (rsp_tdata[63:32] !== e.im) report_mismatch("res_im", rsp_tdata[63:32], e.im);
            if (rsp_tdata[65:64] !== e.status)
               report_mismatch("status", 32'(rsp_tdata[65:64]), 32'(e.status));
         end
         n_checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout: %0d sent, %0d checked", n_sent, n_checked);
         $display("complex_arithmetic_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic [2:0] op;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      req_fire = 1'b0;
      long_hold_done = 1'b0;
      n_total = 0; n_sent = 0; n_checked = 0; n_errors = 0; cycles = 0;
      burst_left = 0; gap_left = 0; hold_left = 0; stall_pct = 0;
      foreach (op_seen[i]) op_seen[i] = 0;

      // directed corners
      add_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
      add_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
      add_item(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      add_item(OP_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
      add_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_item(OP_MUL, 32'h0001_8000, 32'hffff_0000, 32'h0002_0000, 32'h0000_4000);
      add_item(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
      add_item(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
      add_item(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
      add_item(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
      add_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_item(OP_DIV, 32'hffff_fffd, 32'h0, 32'h0002_0000, 32'h0);
      add_item(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h8765_4321);
      add_item(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      add_item(OP_MAG, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
      add_item(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
      add_item(3'd5, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
      add_item(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      add_item(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1);

      for (int i = 0; i < N_RANDOM; i++) begin
         op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         add_item(op, rand_part(), rand_part(), rand_part(), rand_part());
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (n_sent == n_total && expected_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d transfers: add %0d sub %0d mul %0d div %0d mag %0d other %0d",
               n_checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
               op_seen[5] + op_seen[6] + op_seen[7]);
      $display("with bursty input, random output stalls and one long output hold-off");
      if (n_errors == 0 && expected_rsp.size() == 0)
         $display("complex_arithmetic_unit_tb: PASS");
      else
         $display("complex_arithmetic_unit_tb: FAIL");
      $finish;
   end

endmodule
